// ===== rtl/aesd_pkg.sv =====
package aesd_pkg;

	localparam int Rounds = 10;
	localparam int NumKeys = Rounds + 1;

	// configuration register indexes
	localparam logic [0:0] REG_KEY_HIGH = 1'b0;
	localparam logic [0:0] REG_KEY_LOW  = 1'b1;

	// GF(2^8) multiply by x
	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// general GF(2^8) multiply, eight narrow steps
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] p;
		x = a;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ x;
			x = xtime(x);
		end
		gf_mul = p;
	endfunction

	function automatic logic [7:0] gf_inv(input logic [7:0] a);
		logic [7:0] r;
		logic [7:0] b;
		r = 8'h01;
		b = a;
		for (int i = 0; i < 8; i++) begin
			if (i != 0) r = gf_mul(r, b);
			b = gf_mul(b, b);
		end
		gf_inv = r;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
		rotl8 = (v << n) | (v >> (8 - n));
	endfunction

	function automatic logic [7:0] sbox_calc(input logic [7:0] x);
		logic [7:0] b;
		b = gf_inv(x);
		sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
	endfunction

	function automatic logic [7:0] inv_sbox_calc(input logic [7:0] x);
		inv_sbox_calc = gf_inv(rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05);
	endfunction

	typedef logic [7:0] byte_arr_t [256];

	function automatic byte_arr_t make_sbox();
		byte_arr_t t;
		for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
		return t;
	endfunction

	function automatic byte_arr_t make_inv_sbox();
		byte_arr_t t;
		for (int i = 0; i < 256; i++) t[i] = inv_sbox_calc(8'(i));
		return t;
	endfunction

	localparam byte_arr_t SBOX = make_sbox();
	localparam byte_arr_t INV_SBOX = make_inv_sbox();

	// inverse shift rows then inverse S-box; byte i = bits [127-8i -: 8]
	function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[127 - 8 * (r + 4 * c) -: 8] =
					INV_SBOX[s[127 - 8 * (r + 4 * ((c - r + 4) % 4)) -: 8]];
		return t;
	endfunction

	function automatic logic [127:0] inv_mix(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 32 * c -: 8];
			a1 = s[119 - 32 * c -: 8];
			a2 = s[111 - 32 * c -: 8];
			a3 = s[103 - 32 * c -: 8];
			t[127 - 32 * c -: 8] = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11)
				^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9);
			t[119 - 32 * c -: 8] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14)
				^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13);
			t[111 - 32 * c -: 8] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9)
				^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11);
			t[103 - 32 * c -: 8] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13)
				^ gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14);
		end
		return t;
	endfunction

	// one key expansion step: next round key from the previous one
	function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96];
		w1 = k[95:64];
		w2 = k[63:32];
		w3 = k[31:0];
		t = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]}
			^ {rc, 24'h0};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

// ===== rtl/aes128_block_decrypt_core.sv =====
// Channel | Dir | Signals                       | Payload
// s_axis  | in  | s_axis_tvalid/tready/tdata    | ciphertext block
// m_axis  | out | m_axis_tvalid/tready/tdata    | plaintext block
// cfg     | in  | cfg_we/cfg_index/cfg_wdata    | key halves
//
// Eleven pipeline stages: stage 1 adds round key 10 and does inverse shift/sub,
// stages 2..10 each run one inverse round, stage 11 adds round key 0.
// One block may enter every cycle while m_axis does not stall.
// A key write restarts an expansion sequencer that fills the round key
// registers one round per cycle. Reset clears the valid bits, key halves and sequencer, not round keys or data.
// A stall on m_axis holds every full stage; an empty stage still loads from the one
// behind it, so bubbles are squeezed out and nothing is lost or repeated.
module aes128_block_decrypt_core
	import aesd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [63:0] cipher_high, [127:64] cipher_low
	input  logic [127:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [63:0] plain_high, [127:64] plain_low
	output logic [127:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [63:0]  cfg_wdata
);

	localparam int NStg = NumKeys;

	logic [63:0]  key_high_q, key_low_q;
	logic [127:0] rk_q [NumKeys];
	logic [3:0]   exp_cnt_q;
	logic         exp_busy_q;
	logic [7:0]   rcon_q;

	// key registers and expansion sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			exp_busy_q <= 1'b0;
			exp_cnt_q  <= '0;
			rcon_q     <= 8'h01;
		end else if (cfg_we) begin
			if (cfg_index == REG_KEY_HIGH) key_high_q <= cfg_wdata;
			else key_low_q <= cfg_wdata;
			exp_busy_q <= 1'b1;
			exp_cnt_q  <= 4'd0;
			rcon_q     <= 8'h01;
		end else if (exp_busy_q) begin
			rcon_q    <= xtime(rcon_q);
			exp_cnt_q <= exp_cnt_q + 4'd1;
			if (exp_cnt_q == 4'(Rounds - 1)) exp_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exp_busy_q && !cfg_we) begin
			if (exp_cnt_q == 4'd0) rk_q[0] <= {key_high_q, key_low_q};
			rk_q[exp_cnt_q + 4'd1] <= key_step(
				(exp_cnt_q == 4'd0) ? {key_high_q, key_low_q} : rk_q[exp_cnt_q], rcon_q);
		end
	end

	// pipeline
	logic         vld_s [NStg];
	logic [127:0] dat_s [NStg];
	logic         adv [NStg];

	always_comb begin
		adv[NStg-1] = !vld_s[NStg-1] || m_axis_tready;
		for (int i = NStg - 2; i >= 0; i--) adv[i] = !vld_s[i] || adv[i+1];
	end

	// state keeps byte 0 at the top; tdata carries the high half in the low bits
	assign s_axis_tready = adv[0];
	assign m_axis_tvalid = vld_s[NStg-1];
	assign m_axis_tdata  = {dat_s[NStg-1][63:0], dat_s[NStg-1][127:64]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NStg; i++) vld_s[i] <= 1'b0;
		end else begin
			if (adv[0]) vld_s[0] <= s_axis_tvalid;
			for (int i = 1; i < NStg; i++) if (adv[i]) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0])
			dat_s[0] <= inv_shift_sub({s_axis_tdata[63:0], s_axis_tdata[127:64]}
				^ rk_q[Rounds]);
		for (int i = 1; i < NStg - 1; i++)
			if (adv[i]) dat_s[i] <= inv_shift_sub(inv_mix(dat_s[i-1] ^ rk_q[Rounds - i]));
		if (adv[NStg-1]) dat_s[NStg-1] <= dat_s[NStg-2] ^ rk_q[0];
	end

	// assertions
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[0] |-> s_axis_tready)
		else $error("first stage empty but not ready");
	a_exp_end: assert property (@(posedge clk) disable iff (!arst_n)
		exp_busy_q |-> exp_cnt_q <= 4'(Rounds - 1))
		else $error("expansion counter overran");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import aesd_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// [63:0] cipher_high, [127:64] cipher_low
	logic [127:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// [63:0] plain_high, [127:64] plain_low
	logic [127:0] m_axis_tdata;
	logic         cfg_we;
	logic [0:0]   cfg_index;
	logic [63:0]  cfg_wdata;

	aes128_block_decrypt_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [7:0]   fwd_box [256];
	logic [7:0]   rev_box [256];
	logic [63:0]  cur_key_high, cur_key_low;
	logic [127:0] round_keys [11];
	logic [127:0] plain_queue [$];
	int           fail_count;
	bit           tx_idle_on, rx_idle_on;
	int           rx_hold;

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	// S-box tables from the field inverse and the affine map
	task automatic build_boxes();
		logic [7:0] inv, s;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h00;
			for (int y = 1; y < 256; y++)
				if (gmul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
			s = 8'h63;
			for (int k = 0; k < 5; k++)
				s ^= (inv << k) | (inv >> (8 - k));
			fwd_box[x] = s;
			rev_box[s] = 8'(x);
		end
	endtask

	// standard AES-128 schedule into round_keys
	task automatic expand_schedule();
		logic [31:0] w [44];
		logic [31:0] t;
		logic [7:0]  rc;
		rc = 8'h01;
		w[0] = cur_key_high[63:32];
		w[1] = cur_key_high[31:0];
		w[2] = cur_key_low[63:32];
		w[3] = cur_key_low[31:0];
		for (int i = 4; i < 44; i++) begin
			t = w[i - 1];
			if (i % 4 == 0) begin
				t = {fwd_box[t[23:16]], fwd_box[t[15:8]], fwd_box[t[7:0]], fwd_box[t[31:24]]}
					^ {rc, 24'h0};
				rc = gmul(rc, 8'h02);
			end
			w[i] = w[i - 4] ^ t;
		end
		for (int r = 0; r < 11; r++)
			round_keys[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
	endtask

	// inverse cipher; byte i sits at bits [127-8i -: 8]
	function automatic logic [127:0] decrypt_block(input logic [127:0] c);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3;
		logic [127:0] out;
		for (int i = 0; i < 16; i++) s[i] = c[127 - 8 * i -: 8];
		for (int r = 10; r >= 0; r--) begin
			for (int i = 0; i < 16; i++) s[i] ^= round_keys[r][127 - 8 * i -: 8];
			if (r == 0) break;
			if (r != 10)
				for (int col = 0; col < 4; col++) begin
					a0 = s[4 * col]; a1 = s[4 * col + 1];
					a2 = s[4 * col + 2]; a3 = s[4 * col + 3];
					s[4 * col] = gmul(a0, 8'd14) ^ gmul(a1, 8'd11)
						^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9);
					s[4 * col + 1] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14)
						^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13);
					s[4 * col + 2] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9)
						^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11);
					s[4 * col + 3] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13)
						^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14);
				end
			for (int col = 0; col < 4; col++)
				for (int row = 0; row < 4; row++)
					t[row + 4 * col] = rev_box[s[row + 4 * ((col - row + 4) % 4)]];
			s = t;
		end
		for (int i = 0; i < 16; i++) out[127 - 8 * i -: 8] = s[i];
		return out;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (p < 65) return 0;
		if (p < 95) return $urandom_range(3, 1);
		return $urandom_range(60, 20);
	endfunction

	// sink stall pattern
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if (rx_idle_on) rx_hold <= pick_gap();
		end
	end

	// result check against oldest expected plaintext
	always @(posedge clk) begin
		logic [127:0] want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (plain_queue.size() == 0) begin
				$error("unexpected plaintext transfer %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = plain_queue.pop_front();
				if (m_axis_tdata[63:0] !== want[127:64]) begin
					$error("plain_high expected %h actual %h", want[127:64], m_axis_tdata[63:0]);
					fail_count++;
				end
				if (m_axis_tdata[127:64] !== want[63:0]) begin
					$error("plain_low expected %h actual %h", want[63:0], m_axis_tdata[127:64]);
					fail_count++;
				end
			end
		end
	end

	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
		int gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {lo, hi};
		do @(posedge clk); while (!s_axis_tready);
		plain_queue.push_back(decrypt_block({hi, lo}));
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// stop sending, let the pipeline empty out
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (plain_queue.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	// key register write, then a wait for the key expansion to finish
	task automatic write_key(input logic [0:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_KEY_HIGH) cur_key_high = val;
		else cur_key_low = val;
		expand_schedule();
		repeat (15) @(posedge clk);
	endtask

	task automatic test_known_vector();
		logic [127:0] known;
		write_key(REG_KEY_HIGH, 64'h0001020304050607);
		write_key(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		known = decrypt_block(128'h69c4e0d86a7b0430d8cdb78070b4c55a);
		if (known !== 128'h00112233445566778899aabbccddeeff) begin
			$error("predictor plaintext expected %h actual %h",
				128'h00112233445566778899aabbccddeeff, known);
			fail_count++;
		end
		send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
		drain();
	endtask

	task automatic test_extremes();
		logic [63:0] vals [4] = '{64'h0, '1, 64'h8000000000000001, 64'h5555aaaa5555aaaa};
		for (int k = 0; k < 2; k++) begin
			write_key(REG_KEY_HIGH, k ? '1 : 64'h0);
			write_key(REG_KEY_LOW, k ? '1 : 64'h0);
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 2; j++)
					send_block(vals[i], vals[(i + j) % 4]);
			drain();
		end
	endtask

	// one half rewritten, other half kept
	task automatic test_half_key();
		write_key(REG_KEY_LOW, {$urandom, $urandom});
		send_block({$urandom, $urandom}, {$urandom, $urandom});
		drain();
		write_key(REG_KEY_HIGH, {$urandom, $urandom});
		send_block({$urandom, $urandom}, {$urandom, $urandom});
		drain();
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 14; ph++) begin
			write_key(REG_KEY_HIGH, {$urandom, $urandom});
			write_key(REG_KEY_LOW, {$urandom, $urandom});
			tx_idle_on = (ph % 4 != 1);
			rx_idle_on = (ph % 4 != 2);
			repeat (122) send_block({$urandom, $urandom}, {$urandom, $urandom});
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b1;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_HIGH;
		cfg_wdata = '0;
		cur_key_high = '0;
		cur_key_low = '0;
		fail_count = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		rx_hold = 0;
		build_boxes();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_known_vector();
		test_extremes();
		test_half_key();
		test_random_phases();
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/aesd_pkg.sv
rtl/aes128_block_decrypt_core.sv
tb/testbench.sv
